// ----- sv/utf8_cjk_bigram_tokenizer_macros.svh -----
// Assertion macros for the CJK bigram tokenizer checker.
// No dependencies; included by the checker file only.
`ifndef UTF8_CJK_BIGRAM_TOKENIZER_MACROS_SVH
`define UTF8_CJK_BIGRAM_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define UCBT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ucbt assertion failed");

// Next-cycle implication, disabled while reset is active.
`define UCBT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ucbt assertion failed");

`endif

// ----- sv/ucbt_pkg.sv -----
// Shared types, constants and classification functions of the tokenizer.
// No dependencies; used by every other file but the macro header.
package ucbt_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned CpW      = 21;
  localparam int unsigned MaxRes   = 4;
  localparam int unsigned CntW     = $clog2(MaxRes + 1);
  localparam int unsigned SlotIdxW = $clog2(MaxRes);
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  // UTF-8 lead and second-byte limits
  localparam logic [ByteW-1:0] Lead2Lo    = 8'hC2;
  localparam logic [ByteW-1:0] Lead2Hi    = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Lo    = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Sur   = 8'hED;
  localparam logic [ByteW-1:0] Lead3Hi    = 8'hEF;
  localparam logic [ByteW-1:0] Lead4Lo    = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Hi    = 8'hF4;
  localparam logic [ByteW-1:0] Cont3Min   = 8'hA0;
  localparam logic [ByteW-1:0] Cont4Min   = 8'h90;
  localparam logic [ByteW-1:0] Cont4Max   = 8'h8F;

  typedef enum logic [1:0] {
    KIND_ASCII   = 2'd0,
    KIND_UNIGRAM = 2'd1,
    KIND_BIGRAM  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [CharW-1:0] ascii_char;
    logic [CpW-1:0]   first_cp;
    logic [CpW-1:0]   second_cp;
    logic             token_end;
  } tok_t;

  // All results caused by one byte, in emit order from slot 0.
  typedef struct packed {
    logic [CntW-1:0]         cnt;
    tok_t [MaxRes-1:0]       slot;
  } bundle_t;

  function automatic logic is_word(input logic [ByteW-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F || c == 8'h2D;
  endfunction

  function automatic logic is_cjk(input logic [CpW-1:0] cp);
    return (cp >= 21'h03400 && cp <= 21'h04DBF) || (cp >= 21'h04E00 && cp <= 21'h09FFF) ||
           (cp >= 21'h0F900 && cp <= 21'h0FAFF) || (cp >= 21'h20000 && cp <= 21'h2A6DF) ||
           (cp >= 21'h2A700 && cp <= 21'h2EBEF) || (cp >= 21'h30000 && cp <= 21'h3134F);
  endfunction

endpackage

// ----- sv/ucbt_if.sv -----
// Channel interfaces of the tokenizer: byte input and token output.
// Depends on ucbt_pkg for field widths.
interface ucbt_byte_if;
  import ucbt_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface ucbt_tok_if;
  import ucbt_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       token_kind;
  logic [CharW-1:0] ascii_char;
  logic [CpW-1:0]   first_codepoint;
  logic [CpW-1:0]   second_codepoint;
  logic             token_end;
  logic             run_last;
  modport source (output valid, token_kind, ascii_char, first_codepoint, second_codepoint,
                  token_end, run_last, input ready);
  modport sink   (input valid, token_kind, ascii_char, first_codepoint, second_codepoint,
                  token_end, run_last, output ready);
endinterface

// ----- sv/ucbt_front.sv -----
// Front part: UTF-8 decode, word/CJK classification and token state.
// Depends on ucbt_pkg and ucbt_byte_if; emits one result bundle per accepted byte that causes a result.
module ucbt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ucbt_byte_if.sink          in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output ucbt_pkg::bundle_t  bundle_o
);
  import ucbt_pkg::*;

  typedef enum logic [2:0] {
    RUN_NONE = 3'b001,
    RUN_ONE  = 3'b010,
    RUN_MANY = 3'b100
  } run_e;

  typedef struct packed {
    logic [CharW-1:0] pend;
    logic             pvalid;
    logic [CpW-1:0]   prev;
    run_e             run;
    logic [CpW-1:0]   acc;
    logic [1:0]       rem;
    logic [ByteW-1:0] lead;
  } st_t;

  localparam st_t StReset = '{pend: '0, pvalid: 1'b0, prev: '0, run: RUN_NONE,
                              acc: '0, rem: '0, lead: '0};

  st_t              st_q, st_d;
  bundle_t          bnd_d;
  logic             accept;
  logic             do_fresh;
  logic [CpW-1:0]   cp;
  logic [ByteW-1:0] c;

  function automatic void put(inout bundle_t b, input tok_t t);
    if (b.cnt < CntW'(MaxRes)) begin
      b.slot[b.cnt[SlotIdxW-1:0]] = t;
      b.cnt = b.cnt + 1'b1;
    end
  endfunction

  function automatic void flush_cjk(inout st_t s, inout bundle_t b);
    if (s.run == RUN_ONE) begin
      put(b, '{kind: KIND_UNIGRAM, ascii_char: '0, first_cp: s.prev, second_cp: '0,
               token_end: 1'b0});
    end
    s.run  = RUN_NONE;
    s.prev = '0;
  endfunction

  function automatic void flush_ascii(inout st_t s, inout bundle_t b);
    if (s.pvalid) begin
      put(b, '{kind: KIND_ASCII, ascii_char: s.pend, first_cp: '0, second_cp: '0,
               token_end: 1'b1});
    end
    s.pvalid = 1'b0;
    s.pend   = '0;
  endfunction

  function automatic void drop_seq(inout st_t s);
    s.rem  = '0;
    s.acc  = '0;
    s.lead = '0;
  endfunction

  function automatic logic second_bad(input st_t s, input logic [ByteW-1:0] b);
    logic bad;
    bad = 1'b0;
    if (s.lead >= Lead3Lo && s.lead <= Lead3Hi && s.rem == 2'd2) begin
      if (s.lead == Lead3Lo && b < Cont3Min) bad = 1'b1;
      if (s.lead == Lead3Sur && b >= Cont3Min) bad = 1'b1;
    end
    if (s.lead >= Lead4Lo && s.lead <= Lead4Hi && s.rem == 2'd3) begin
      if (s.lead == Lead4Lo && b < Cont4Min) bad = 1'b1;
      if (s.lead == Lead4Hi && b > Cont4Max) bad = 1'b1;
    end
    return bad;
  endfunction

  assign c           = in_i.text_byte;
  assign in_i.ready  = !q_full_i;
  assign accept      = in_i.valid && !q_full_i;

  always_comb begin
    st_d     = st_q;
    bnd_d    = '0;
    cp       = '0;
    do_fresh = (st_q.rem == '0);

    // continuation of a pending sequence
    if (st_q.rem != '0) begin
      if (c[7:6] != 2'b10) begin
        // broken sequence: drop it and take this byte again as a fresh one
        drop_seq(st_d);
        flush_cjk(st_d, bnd_d);
        do_fresh = 1'b1;
      end else if (second_bad(st_q, c)) begin
        drop_seq(st_d);
        flush_cjk(st_d, bnd_d);
      end else begin
        st_d.acc = {st_q.acc[CpW-7:0], c[5:0]};
        st_d.rem = st_q.rem - 2'd1;
        if (st_d.rem == '0) begin
          cp = st_d.acc;
          drop_seq(st_d);
          if (is_cjk(cp)) begin
            if (st_d.run != RUN_NONE) begin
              put(bnd_d, '{kind: KIND_BIGRAM, ascii_char: '0, first_cp: st_d.prev,
                           second_cp: cp, token_end: 1'b0});
              st_d.run = RUN_MANY;
            end else begin
              st_d.run = RUN_ONE;
            end
            st_d.prev = cp;
          end else begin
            flush_cjk(st_d, bnd_d);
          end
        end
      end
    end

    if (do_fresh) begin
      if (!c[7]) begin
        flush_cjk(st_d, bnd_d);
        if (is_word(c)) begin
          if (st_d.pvalid) begin
            put(bnd_d, '{kind: KIND_ASCII, ascii_char: st_d.pend, first_cp: '0,
                         second_cp: '0, token_end: 1'b0});
          end
          // lower-case A-Z
          st_d.pend   = (c >= 8'h41 && c <= 8'h5A) ? (c[CharW-1:0] + 7'd32) : c[CharW-1:0];
          st_d.pvalid = 1'b1;
        end else begin
          flush_ascii(st_d, bnd_d);
        end
      end else begin
        flush_ascii(st_d, bnd_d);
        st_d.lead = c;
        if (c >= Lead2Lo && c <= Lead2Hi) begin
          st_d.acc = CpW'(c[4:0]);
          st_d.rem = 2'd1;
        end else if (c >= Lead3Lo && c <= Lead3Hi) begin
          st_d.acc = CpW'(c[3:0]);
          st_d.rem = 2'd2;
        end else if (c >= Lead4Lo && c <= Lead4Hi) begin
          st_d.acc = CpW'(c[2:0]);
          st_d.rem = 2'd3;
        end else begin
          drop_seq(st_d);
          flush_cjk(st_d, bnd_d);
        end
      end
    end

    // end of text: flush everything and restart
    if (in_i.end_of_text) begin
      if (st_d.rem != '0) begin
        drop_seq(st_d);
        flush_cjk(st_d, bnd_d);
      end
      flush_ascii(st_d, bnd_d);
      flush_cjk(st_d, bnd_d);
      st_d = StReset;
    end
  end

  assign push_o   = accept && (bnd_d.cnt != '0);
  assign bundle_o = bnd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

endmodule

// ----- sv/ucbt_queue.sv -----
// Short bundle queue between the front and back parts.
// Depends on ucbt_pkg for the bundle type and depth.
module ucbt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ucbt_pkg::bundle_t  data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output ucbt_pkg::bundle_t  data_o
);
  import ucbt_pkg::*;

  bundle_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/ucbt_back.sv -----
// Back part: walks the slots of the head bundle into the output register.
// Depends on ucbt_pkg and ucbt_tok_if.
module ucbt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ucbt_pkg::bundle_t  head_i,
  output logic               pop_o,
  ucbt_tok_if.source         out_o
);
  import ucbt_pkg::*;

  logic [SlotIdxW-1:0] idx_q;
  logic                valid_q;
  tok_t                tok_q;
  logic                last_q;
  logic                load;
  logic                last_slot;
  tok_t                cur;

  assign load      = q_valid_i && (!valid_q || out_o.ready);
  assign cur       = head_i.slot[idx_q];
  assign last_slot = (CntW'(idx_q) == (head_i.cnt - CntW'(1)));
  assign pop_o     = load && last_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last_slot ? '0 : idx_q + 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= cur;
      last_q <= last_slot;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.token_kind       = tok_q.kind;
  assign out_o.ascii_char       = tok_q.ascii_char;
  assign out_o.first_codepoint  = tok_q.first_cp;
  assign out_o.second_codepoint = tok_q.second_cp;
  assign out_o.token_end        = tok_q.token_end;
  assign out_o.run_last         = last_q;

endmodule

// ----- sv/utf8_cjk_bigram_tokenizer.sv -----
// UTF-8 tokenizer with ASCII words and CJK bigrams, top level.
// Depends on ucbt_pkg, ucbt_if, ucbt_front, ucbt_queue and ucbt_back.
//
// Usage: text bytes enter on in_i (valid/ready), one byte per item, with
// end_of_text on the final byte of a text. Tokens leave on out_o, one per
// item: lower-cased ASCII word characters (token_end on the last character
// of a word), CJK unigrams and bigrams as codepoints. run_last marks the
// last token caused by one input byte; a byte may cause none.
// The first token of a byte is registered in the bundle queue, then in the
// output register. Throughput: one byte per cycle while each byte causes
// at most one token and the receiver does not stall; a byte causing more
// tokens holds the output register until all are out, and the two-entry
// bundle queue between decoder and output keeps the decoder running.
// Reset clears the decoder state, the queue and the output valid; the next
// byte starts a new text. When the receiver stalls, the output token holds,
// the queue fills and in_i.ready drops once two bundles wait.
module utf8_cjk_bigram_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  ucbt_byte_if.sink   in_i,
  ucbt_tok_if.source  out_o
);
  import ucbt_pkg::*;

  logic    push, full, q_valid, pop;
  bundle_t bnd_in, bnd_head;

  ucbt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .push_o   (push),
    .bundle_o (bnd_in)
  );

  ucbt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (bnd_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (bnd_head)
  );

  ucbt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (bnd_head),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

// ----- sv/ucbt_checker.sv -----
// Port-level checks on the tokenizer output, bound to the top level.
// Depends on ucbt_pkg and utf8_cjk_bigram_tokenizer_macros.svh.
`include "utf8_cjk_bigram_tokenizer_macros.svh"

module ucbt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [1:0]                 token_kind_i,
  input logic [ucbt_pkg::CharW-1:0] ascii_char_i,
  input logic [ucbt_pkg::CpW-1:0]   first_codepoint_i,
  input logic [ucbt_pkg::CpW-1:0]   second_codepoint_i,
  input logic                       token_end_i,
  input logic                       run_last_i
);
  import ucbt_pkg::*;

  localparam int unsigned PayW = 2 + CharW + 2 * CpW + 2;

  logic [PayW-1:0] payload;
  logic            stall;
  logic            ascii_tok, uni_tok, bi_tok;
  logic            cps_zero, second_zero, no_word;

  assign payload     = {token_kind_i, ascii_char_i, first_codepoint_i, second_codepoint_i,
                        token_end_i, run_last_i};
  assign stall       = out_valid_i && !out_ready_i;
  assign ascii_tok   = out_valid_i && (token_kind_i == KIND_ASCII);
  assign uni_tok     = out_valid_i && (token_kind_i == KIND_UNIGRAM);
  assign bi_tok      = out_valid_i && (token_kind_i == KIND_BIGRAM);
  assign second_zero = (second_codepoint_i == '0);
  assign cps_zero    = (first_codepoint_i == '0) && second_zero;
  assign no_word     = (ascii_char_i == '0) && !token_end_i;

  `UCBT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, stall, out_valid_i && $stable(payload))
  `UCBT_ASSERT_IMP(a_ascii_clean, clk_i, rst_ni, ascii_tok, cps_zero)
  `UCBT_ASSERT_IMP(a_unigram_clean, clk_i, rst_ni, uni_tok, second_zero && no_word)
  `UCBT_ASSERT_IMP(a_bigram_clean, clk_i, rst_ni, bi_tok, no_word)

endmodule

bind utf8_cjk_bigram_tokenizer ucbt_checker u_ucbt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .token_kind_i       (out_o.token_kind),
  .ascii_char_i       (out_o.ascii_char),
  .first_codepoint_i  (out_o.first_codepoint),
  .second_codepoint_i (out_o.second_codepoint),
  .token_end_i        (out_o.token_end),
  .run_last_i         (out_o.run_last)
);
